FILE: rtl/crt5_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt5_pkg: shared constants and types for five-modulus CRT reconstruction
// Moduli, Garner inverses, cross-modulus weights and the word carried
// down the digit pipeline.
// ----------------------------------------------------------------------------
package crt5_pkg;

  localparam int NUM_MOD    = 5;
  localparam int RES_W      = 31;   // widest residue / modular value
  localparam int SUM_W      = 64;
  localparam int MODMUL_LAT = 5;    // stages in one modular multiply unit
  localparam int DIGIT_LAT  = 1 + 2 * MODMUL_LAT;

  // Prime moduli, all within 2^18 of 2^30
  localparam logic [RES_W-1:0] MOD0 = 31'd1073643521;
  localparam logic [RES_W-1:0] MOD1 = 31'd1073692673;
  localparam logic [RES_W-1:0] MOD2 = 31'd1073750017;
  localparam logic [RES_W-1:0] MOD3 = 31'd1073815553;
  localparam logic [RES_W-1:0] MOD4 = 31'd1073872897;

  localparam logic [0:NUM_MOD-1][RES_W-1:0] MOD_TAB = '{MOD0, MOD1, MOD2, MOD3, MOD4};

  // Inverse of the product of all lower moduli, modulo modulus k
  localparam logic [1:NUM_MOD-1][RES_W-1:0] INV_TAB =
    '{31'd357919402, 31'd589973977, 31'd197295683, 31'd1004546623};

  // Running products of moduli, wrapped to 64 bits
  localparam logic [SUM_W-1:0] P01   = 64'(MOD0) * 64'(MOD1);
  localparam logic [SUM_W-1:0] P012  = P01 * 64'(MOD2);
  localparam logic [SUM_W-1:0] P0123 = P012 * 64'(MOD3);

  localparam logic [1:NUM_MOD-1][SUM_W-1:0] WFULL_TAB = '{64'(MOD0), P01, P012, P0123};

  // Weight of digit j reduced modulo modulus k (j < k); exact, no 64-bit wrap
  localparam logic [RES_W-1:0] W23 = 31'(P01 % 64'(MOD3));
  localparam logic [RES_W-1:0] W24 = 31'(P01 % 64'(MOD4));
  localparam logic [RES_W-1:0] W34 = 31'((64'(W24) * 64'(MOD2)) % 64'(MOD4));

  localparam logic [1:NUM_MOD-1][1:NUM_MOD-1][RES_W-1:0] XW_TAB = '{
    '{31'd0, MOD0,  MOD0,  MOD0},
    '{31'd0, 31'd0, W23,   W24},
    '{31'd0, 31'd0, 31'd0, W34},
    '{31'd0, 31'd0, 31'd0, 31'd0}
  };

  // Word carried between digit steps
  typedef struct packed {
    logic [NUM_MOD-1:1][RES_W-1:0] rr;   // residues reduced modulo their modulus
    logic [NUM_MOD-1:1][RES_W-1:0] acc;  // running value modulo each modulus
    logic [SUM_W-1:0]              sum;  // running value, low 64 bits
  } crt5_item_t;

endpackage
`default_nettype wire

FILE: rtl/crt5_garner_reconstruct_core.sv
`default_nettype none
// A result is offered once its input word has passed the input register,
//   four 11-stage digit steps and the output buffer.
// Throughput: one word per cycle while the output buffer has room; each
//   digit step is a subtract stage plus two 5-stage modmul units in lockstep.
// Reset: synchronous active-low rst_n clears the valid bits and the
//   two-entry output buffer count; data registers are not reset.
// ----------------------------------------------------------------------------
// crt5_garner_reconstruct_core: five-modulus Garner CRT reconstruction
// Rebuilds the low 64 bits of an integer from five residues near 2^30,
// fully pipelined, with a two-entry output buffer decoupling the stall.
// ----------------------------------------------------------------------------
module crt5_garner_reconstruct_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [29:0]        in_residue_0,
  input  logic [29:0]        in_residue_1,
  input  logic [30:0]        in_residue_2,
  input  logic [30:0]        in_residue_3,
  input  logic [30:0]        in_residue_4,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_combined_value
);
  import crt5_pkg::*;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  logic                            en;
  logic [NUM_MOD-1:0][RES_W-1:0]   res_w;
  crt5_item_t                      p0_nxt;
  crt5_item_t                      p0_item_r;
  logic                            p0_valid_r;
  crt5_item_t                      link_item [0:NUM_MOD-1];
  logic [NUM_MOD-1:0]              link_valid;
  logic                            push, pop;
  logic [1:0]                      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]                head_r, head_nxt;
  logic [SUM_W-1:0]                skid_r, skid_nxt;

  // pipeline advances whenever the output buffer has room
  assign en       = (cnt_r != BUF_FULL);
  assign in_ready = en;

  // input stage: reduce residues, seed running values
  assign res_w = {in_residue_4, in_residue_3, in_residue_2,
                  {1'b0, in_residue_1}, {1'b0, in_residue_0}};

  always_comb begin
    p0_nxt.sum = 64'(in_residue_0);
    for (int k = 1; k < NUM_MOD; k++) begin
      p0_nxt.rr[k]  = (res_w[k] >= MOD_TAB[k]) ? (res_w[k] - MOD_TAB[k]) : res_w[k];
      p0_nxt.acc[k] = (res_w[0] >= MOD_TAB[k]) ? (res_w[0] - MOD_TAB[k]) : res_w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_item_r <= p0_nxt;
    end
  end

  assign link_item[0]  = p0_item_r;
  assign link_valid[0] = p0_valid_r;

  // digit steps 1..4
  for (genvar d = 1; d < NUM_MOD; d++) begin : g_digit
    crt5_digit #(.DIGIT(d)) u_digit (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (link_valid[d-1]),
      .in_item   (link_item[d-1]),
      .out_valid (link_valid[d]),
      .out_item  (link_item[d])
    );
  end

  // two-entry output buffer
  assign push      = en && link_valid[NUM_MOD-1];
  assign out_valid = (cnt_r != BUF_EMPTY);
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (push && !pop) begin
      if (cnt_r == BUF_EMPTY) begin
        head_nxt = link_item[NUM_MOD-1].sum;
      end else begin
        skid_nxt = link_item[NUM_MOD-1].sum;
      end
      cnt_nxt = cnt_r + BUF_ONE;
    end else if (!push && pop) begin
      head_nxt = skid_r;
      cnt_nxt  = cnt_r - BUF_ONE;
    end else if (push && pop) begin
      head_nxt = link_item[NUM_MOD-1].sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BUF_EMPTY;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_combined_value = $signed(head_r);

`ifndef ASSERT_OFF
  // buffer count stays within two entries
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  // an accepted word always lands in the input stage
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> p0_valid_r)
    else $error("accepted word lost at input stage");

  // a full buffer that is not drained keeps its head word
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == BUF_FULL && !out_ready) |=> ($stable(head_r) && cnt_r == BUF_FULL))
    else $error("full output buffer changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/crt5_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt5_modmul: pipelined (a*b + c) mod MODULUS
// Five stages: product, then three signed folds of the bits above 2^30
// using 2^30 = -(MODULUS - 2^30), then a last fold and one correction.
// ----------------------------------------------------------------------------
module crt5_modmul #(
  parameter logic [crt5_pkg::RES_W-1:0] MODULUS = crt5_pkg::MOD1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [crt5_pkg::RES_W-1:0]  a,
  input  logic [crt5_pkg::RES_W-1:0]  b,
  input  logic [crt5_pkg::RES_W-1:0]  c,
  output logic [crt5_pkg::RES_W-1:0]  y
);
  import crt5_pkg::*;

  localparam int                OFS_I = int'(MODULUS) - (1 << 30);
  localparam logic signed [18:0] OFS  = 19'(OFS_I);
  localparam logic signed [31:0] MOD_S = $signed({1'b0, MODULUS});

  logic        [62:0] prod_r,  prod_nxt;
  logic signed [52:0] fold1_r, fold1_nxt;
  logic signed [41:0] fold2_r, fold2_nxt;
  logic signed [32:0] fold3_r, fold3_nxt;
  logic [RES_W-1:0]   y_r,     y_nxt;
  logic signed [31:0] lo4;
  logic signed [31:0] t4;
  logic signed [31:0] fix4;

  // product plus addend, below 2^63
  assign prod_nxt = 63'(a) * 63'(b) + 63'(c);

  // folds: x = hi*2^30 + lo  ==  lo - hi*OFS
  assign fold1_nxt = $signed({23'd0, prod_r[29:0]}) - $signed({1'b0, prod_r[62:30]}) * OFS;
  assign fold2_nxt = $signed({12'd0, fold1_r[29:0]}) - $signed(fold1_r[52:30]) * OFS;
  assign fold3_nxt = $signed({3'd0, fold2_r[29:0]}) - $signed(fold2_r[41:30]) * OFS;

  // last fold (high part is -1, 0 or +1) and final correction
  always_comb begin
    lo4 = $signed({2'd0, fold3_r[29:0]});
    if (fold3_r[32]) begin
      t4 = lo4 + OFS;
    end else if (fold3_r[30]) begin
      t4 = lo4 - OFS;
    end else begin
      t4 = lo4;
    end
    if (t4 < 0) begin
      fix4 = t4 + MOD_S;
    end else if (t4 >= MOD_S) begin
      fix4 = t4 - MOD_S;
    end else begin
      fix4 = t4;
    end
    y_nxt = fix4[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      fold1_r <= fold1_nxt;
      fold2_r <= fold2_nxt;
      fold3_r <= fold3_nxt;
      y_r     <= y_nxt;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

FILE: rtl/crt5_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt5_digit: one Garner digit step
// Stage 1 takes (r - acc) mod m, stages 2-6 scale by the inverse to form
// the digit, stages 7-11 fold the digit into the running value modulo every
// higher modulus and into the 64-bit sum.
// ----------------------------------------------------------------------------
module crt5_digit #(
  parameter int DIGIT = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  crt5_pkg::crt5_item_t in_item,
  output logic                 out_valid,
  output crt5_pkg::crt5_item_t out_item
);
  import crt5_pkg::*;

  localparam logic [RES_W-1:0] MOD_J = MOD_TAB[DIGIT];
  localparam logic [RES_W-1:0] INV_J = INV_TAB[DIGIT];
  localparam logic [SUM_W-1:0] WFULL = WFULL_TAB[DIGIT];
  localparam logic [31:0]      W_LO  = WFULL[31:0];
  localparam logic [31:0]      W_HI  = WFULL[63:32];
  localparam logic signed [31:0] MOD_S = $signed({1'b0, MOD_J});

  logic [DIGIT_LAT-1:0] valid_r;
  crt5_item_t           item_r [0:DIGIT_LAT-1];
  logic [RES_W-1:0]     diff_r, diff_nxt;
  logic signed [31:0]   diff_raw;
  logic [RES_W-1:0]     dig;
  logic [RES_W-1:0]     dig7_r;
  logic [62:0]          plo_r;
  logic [31:0]          ph_r;
  logic [SUM_W-1:0]     part_r;
  logic [SUM_W-1:0]     sum9_r, sum10_r, sum11_r;
  logic [RES_W-1:0]     lane_acc [1:NUM_MOD-1];

  // valid bits shift with the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DIGIT_LAT-2:0], in_valid};
    end
  end

  // residue minus running value, mapped into [0, m)
  always_comb begin
    diff_raw = $signed({1'b0, in_item.rr[DIGIT]}) - $signed({1'b0, in_item.acc[DIGIT]});
    if (diff_raw < 0) begin
      diff_raw = diff_raw + MOD_S;
    end
    diff_nxt = diff_raw[RES_W-1:0];
  end

  // word delay line and weighted-sum path
  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int i = 1; i < DIGIT_LAT; i++) begin
        item_r[i] <= item_r[i-1];
      end
      diff_r  <= diff_nxt;
      dig7_r  <= dig;
      plo_r   <= 63'(dig) * 63'(W_LO);
      part_r  <= item_r[MODMUL_LAT+1].sum + 64'(plo_r);
      ph_r    <= 32'(dig7_r) * W_HI;
      sum9_r  <= part_r + {ph_r, 32'd0};
      sum10_r <= sum9_r;
      sum11_r <= sum10_r;
    end
  end

  // digit = diff * inverse mod m
  crt5_modmul #(.MODULUS(MOD_J)) u_inv (
    .clk (clk),
    .en  (en),
    .a   (diff_r),
    .b   (INV_J),
    .c   ({RES_W{1'b0}}),
    .y   (dig)
  );

  // running value modulo each higher modulus
  for (genvar k = 1; k < NUM_MOD; k++) begin : g_lane
    if (k > DIGIT) begin : g_upd
      crt5_modmul #(.MODULUS(MOD_TAB[k])) u_upd (
        .clk (clk),
        .en  (en),
        .a   (dig),
        .b   (XW_TAB[DIGIT][k]),
        .c   (item_r[MODMUL_LAT].acc[k]),
        .y   (lane_acc[k])
      );
    end else begin : g_pass
      assign lane_acc[k] = item_r[DIGIT_LAT-1].acc[k];
    end
  end

  always_comb begin
    out_item     = item_r[DIGIT_LAT-1];
    out_item.sum = sum11_r;
    for (int k = 1; k < NUM_MOD; k++) begin
      out_item.acc[k] = lane_acc[k];
    end
  end

  assign out_valid = valid_r[DIGIT_LAT-1];

endmodule
`default_nettype wire
